>>> design/ddft_pkg.sv
// Shared types, constants and the twiddle conversion function for the direct DFT block.
package ddft_pkg;

    localparam int POINTS_DEF  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int TW_BITS     = 16;
    localparam int PROD_BITS   = SAMPLE_BITS + TW_BITS;
    localparam int ACC_BITS    = 38;
    localparam int BIN_BITS    = 6;

    localparam real TWO_PI   = 6.283185307179586;
    localparam real TW_SCALE = 32768.0;
    localparam real TW_MAX   = 32767.0;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } sample_t;

    // One request to the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } issue_t;

    // Load request for the output register.
    typedef struct packed {
        logic load;
        logic last;
    } emit_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } ctrl_state_t;

    // Round half up to Q1.15 and saturate at the positive end; used at elaboration only.
    function automatic logic signed [TW_BITS-1:0] to_q15(real v);
        real    r;
        integer n;
        r = $floor(v * TW_SCALE + 0.5);
        if (r > TW_MAX)
        begin
            r = TW_MAX;
        end
        n = $rtoi(r);
        return n[TW_BITS-1:0];
    endfunction

endpackage

>>> design/ddft_store.sv
// Sample memory: one write port for incoming samples, one registered read port for the MAC.
module ddft_store #(
    parameter int POINTS = ddft_pkg::POINTS_DEF
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(POINTS)-1:0] wr_addr,
    input  ddft_pkg::sample_t         wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(POINTS)-1:0] rd_addr,
    output ddft_pkg::sample_t         rd_data
);
    import ddft_pkg::*;

    sample_t mem [POINTS];
    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/ddft_mac.sv
// Twiddle ROM and the shared complex multiply-accumulate pipeline.
module ddft_mac #(
    parameter int POINTS = ddft_pkg::POINTS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ddft_pkg::issue_t                        issue,
    input  logic [$clog2(POINTS)-1:0]               tw_idx,
    input  ddft_pkg::sample_t                       sample,
    output logic signed [ddft_pkg::ACC_BITS-1:0]    acc_re,
    output logic signed [ddft_pkg::ACC_BITS-1:0]    acc_im,
    output logic                                    done
);
    import ddft_pkg::*;

    logic signed [TW_BITS-1:0] cos_rom [POINTS];
    logic signed [TW_BITS-1:0] sin_rom [POINTS];

    for (genvar g = 0; g < POINTS; g++)
    begin : g_rom
        localparam real ANGLE = TWO_PI * g / POINTS;
        localparam logic signed [TW_BITS-1:0] COS_Q = to_q15($cos(ANGLE));
        localparam logic signed [TW_BITS-1:0] SIN_Q = to_q15($sin(ANGLE));
        assign cos_rom[g] = COS_Q;
        assign sin_rom[g] = SIN_Q;
    end

    issue_t                      s1_reg;
    issue_t                      s2_reg;
    logic signed [TW_BITS-1:0]   cos_reg;
    logic signed [TW_BITS-1:0]   sin_reg;
    logic signed [PROD_BITS-1:0] p_rc_reg;
    logic signed [PROD_BITS-1:0] p_is_reg;
    logic signed [PROD_BITS-1:0] p_ic_reg;
    logic signed [PROD_BITS-1:0] p_rs_reg;
    logic signed [ACC_BITS-1:0]  acc_re_reg;
    logic signed [ACC_BITS-1:0]  acc_im_reg;
    logic signed [ACC_BITS-1:0]  acc_re_next;
    logic signed [ACC_BITS-1:0]  acc_im_next;
    logic signed [ACC_BITS-1:0]  sum_re;
    logic signed [ACC_BITS-1:0]  sum_im;
    logic                        done_reg;

    // Control flags of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= issue;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg.valid && s2_reg.last;
        end
    end

    // The sample arrives from the store in the same cycle as the twiddle registers.
    always_ff @(posedge clk)
    begin
        cos_reg  <= cos_rom[tw_idx];
        sin_reg  <= sin_rom[tw_idx];
        p_rc_reg <= sample.re * cos_reg;
        p_is_reg <= sample.im * sin_reg;
        p_ic_reg <= sample.im * cos_reg;
        p_rs_reg <= sample.re * sin_reg;
        if (s2_reg.valid)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    always_comb
    begin
        sum_re = ACC_BITS'(p_rc_reg) + ACC_BITS'(p_is_reg);
        sum_im = ACC_BITS'(p_ic_reg) - ACC_BITS'(p_rs_reg);
        if (s2_reg.first)
        begin
            acc_re_next = sum_re;
            acc_im_next = sum_im;
        end
        else
        begin
            acc_re_next = acc_re_reg + sum_re;
            acc_im_next = acc_im_reg + sum_im;
        end
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;
    assign done   = done_reg;

endmodule

>>> design/ddft_ctrl.sv
// Sequencer: loads a frame of samples, then walks bins and samples through the MAC.
module ddft_ctrl #(
    parameter int POINTS = ddft_pkg::POINTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      out_free,
    input  logic                      mac_done,
    output logic                      store_we,
    output logic [$clog2(POINTS)-1:0] store_waddr,
    output logic [$clog2(POINTS)-1:0] store_raddr,
    output ddft_pkg::issue_t          issue,
    output logic [$clog2(POINTS)-1:0] tw_idx,
    output ddft_pkg::emit_t           emit,
    output logic [$clog2(POINTS)-1:0] bin
);
    import ddft_pkg::*;

    localparam int AW = $clog2(POINTS);
    localparam logic [AW-1:0] LAST = AW'(POINTS - 1);
    localparam logic [AW:0]   WRAP = (AW + 1)'(POINTS);

    ctrl_state_t   state_reg;
    ctrl_state_t   state_next;
    logic [AW-1:0] frame_reg;
    logic [AW-1:0] frame_next;
    logic [AW-1:0] bin_reg;
    logic [AW-1:0] bin_next;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] k_next;
    logic [AW-1:0] m_reg;
    logic [AW-1:0] m_next;
    logic [AW:0]   m_sum;
    logic [AW:0]   m_wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            frame_reg <= '0;
            bin_reg   <= '0;
            k_reg     <= '0;
            m_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            frame_reg <= frame_next;
            bin_reg   <= bin_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && frame_reg == LAST)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (k_reg == LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (bin_reg == LAST) ? ST_LOAD : ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // The twiddle index steps by the bin number and wraps modulo the frame length.
    always_comb
    begin
        m_sum  = {1'b0, m_reg} + {1'b0, bin_reg};
        m_wrap = m_sum - WRAP;
        frame_next = frame_reg;
        bin_next   = bin_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    frame_next = (frame_reg == LAST) ? '0 : frame_reg + AW'(1);
                    bin_next   = '0;
                    k_next     = '0;
                    m_next     = '0;
                end
            end
            ST_ISSUE:
            begin
                k_next = k_reg + AW'(1);
                m_next = (m_sum >= WRAP) ? m_wrap[AW-1:0] : m_sum[AW-1:0];
            end
            ST_DRAIN:
            begin
                k_next = '0;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    bin_next = bin_reg + AW'(1);
                    k_next   = '0;
                    m_next   = '0;
                end
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        issue       = '0;
        emit        = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
            end
            ST_ISSUE:
            begin
                issue.valid = 1'b1;
                issue.first = (k_reg == '0);
                issue.last  = (k_reg == LAST);
            end
            ST_DRAIN:
            begin
                issue = '0;
            end
            ST_EMIT:
            begin
                emit.load = out_free;
                emit.last = (bin_reg == LAST);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign store_we    = in_valid && in_ready;
    assign store_waddr = frame_reg;
    assign store_raddr = k_reg;
    assign tw_idx      = m_reg;
    assign bin         = bin_reg;

endmodule

>>> design/direct_dft.sv
// Direct DFT: after the last sample of a frame, each bin in turn takes POINTS passes through
// one complex MAC, a drain of the MAC pipeline, and a load of the output register. The block
// takes no new samples until every bin of the frame has been loaded, since the single shared
// MAC and its sample-store port serve one frame at a time.
// Reset (rst_n low, asynchronous) empties the frame and the output register; the sample
// memory is not cleared, as every entry is written before it is read.
module direct_dft #(
    parameter int POINTS = ddft_pkg::POINTS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [ddft_pkg::SAMPLE_BITS-1:0] sample_re,
    input  logic signed [ddft_pkg::SAMPLE_BITS-1:0] sample_im,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [ddft_pkg::BIN_BITS-1:0]           bin_index,
    output logic signed [ddft_pkg::ACC_BITS-1:0]    bin_re,
    output logic signed [ddft_pkg::ACC_BITS-1:0]    bin_im,
    output logic                                    last_bin
);
    import ddft_pkg::*;

    localparam int AW = $clog2(POINTS);

    logic                       out_free;
    logic                       mac_done;
    logic                       store_we;
    logic [AW-1:0]              store_waddr;
    logic [AW-1:0]              store_raddr;
    logic [AW-1:0]              tw_idx;
    logic [AW-1:0]              bin;
    issue_t                     issue;
    emit_t                      emit;
    sample_t                    wr_sample;
    sample_t                    rd_sample;
    logic signed [ACC_BITS-1:0] acc_re;
    logic signed [ACC_BITS-1:0] acc_im;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [BIN_BITS-1:0]        bin_index_reg;
    logic signed [ACC_BITS-1:0] bin_re_reg;
    logic signed [ACC_BITS-1:0] bin_im_reg;
    logic                       last_bin_reg;

    assign wr_sample.re = sample_re;
    assign wr_sample.im = sample_im;
    assign out_free     = !out_valid_reg || out_ready;

    ddft_ctrl #(.POINTS(POINTS)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_free    (out_free),
        .mac_done    (mac_done),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_raddr (store_raddr),
        .issue       (issue),
        .tw_idx      (tw_idx),
        .emit        (emit),
        .bin         (bin)
    );

    ddft_store #(.POINTS(POINTS)) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (wr_sample),
        .rd_en   (issue.valid),
        .rd_addr (store_raddr),
        .rd_data (rd_sample)
    );

    ddft_mac #(.POINTS(POINTS)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .tw_idx (tw_idx),
        .sample (rd_sample),
        .acc_re (acc_re),
        .acc_im (acc_im),
        .done   (mac_done)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            bin_index_reg <= BIN_BITS'(bin);
            bin_re_reg    <= acc_re;
            bin_im_reg    <= acc_im;
            last_bin_reg  <= emit.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_index = bin_index_reg;
    assign bin_re    = bin_re_reg;
    assign bin_im    = bin_im_reg;
    assign last_bin  = last_bin_reg;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the direct DFT block: frames of random and edge-case samples.
`timescale 1ns / 1ps

module tb_top;
    import ddft_pkg::*;

    localparam int NPTS = POINTS_DEF;
    localparam longint unsigned NPTS_U = NPTS;
    localparam longint unsigned HALF_PI_Q62 = 64'd7244019458077122849;
    localparam longint unsigned ONE_Q62 = 64'd1 << 62;
    localparam int HOLD_CYCLES = 600;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [BIN_BITS-1:0]        index;
        logic signed [ACC_BITS-1:0] re;
        logic signed [ACC_BITS-1:0] im;
        logic                       last;
    } dft_bin_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic                          out_valid;
    logic                          out_ready;
    logic [BIN_BITS-1:0]           bin_index;
    logic signed [ACC_BITS-1:0]    bin_re;
    logic signed [ACC_BITS-1:0]    bin_im;
    logic                          last_bin;

    // Twiddle table and the frame being collected by the predictor.
    int       cos_tw [NPTS];
    int       sin_tw [NPTS];
    int       frame_re [NPTS];
    int       frame_im [NPTS];
    int       frame_fill = 0;
    dft_bin_t bins_due [$];
    dft_bin_t due_bin;

    int   errors = 0;
    int   quiet_cycles = 0;
    int   hold_reqs = 0;
    int   holds_done = 0;
    logic idle_in = 1'b0;
    logic stall_out;

    direct_dft u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample_re (sample_re),
        .sample_im (sample_im),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bin_index (bin_index),
        .bin_re    (bin_re),
        .bin_im    (bin_im),
        .last_bin  (last_bin)
    );

    always #5 clk = ~clk;

    // Bits 125 down to 62 of the full product of two Q62 values, i.e. (a * b) >> 62.
    function automatic longint unsigned q62_mul(input longint unsigned a,
                                                input longint unsigned b);
        bit [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Cos and sin of 2*pi*m/N in Q1.15, from exact Q62 Taylor series with quadrant folding.
    initial
    begin : twiddle_rom
        longint unsigned q, rem, r, x, x2, ct, cs, st, ss, c, s, c15, s15;
        int cv, sv;
        bit swap;
        for (int m = 0; m < NPTS; m++)
        begin
            q    = (4 * longint'(m)) / NPTS_U;
            rem  = 4 * longint'(m) - q * NPTS_U;
            swap = (2 * rem) > NPTS_U;
            r    = swap ? NPTS_U - rem : rem;
            x    = (HALF_PI_Q62 / NPTS_U) * r + ((HALF_PI_Q62 % NPTS_U) * r) / NPTS_U;
            x2   = q62_mul(x, x);
            ct   = ONE_Q62;
            cs   = ONE_Q62;
            st   = x;
            ss   = x;
            for (longint unsigned n = 1; n < 24; n++)
            begin
                ct = q62_mul(ct, x2) / ((2 * n - 1) * (2 * n));
                st = q62_mul(st, x2) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    cs = cs - ct;
                    ss = ss - st;
                end
                else
                begin
                    cs = cs + ct;
                    ss = ss + st;
                end
            end
            c   = swap ? ss : cs;
            s   = swap ? cs : ss;
            c15 = (c + (64'd1 << 46)) >> 47;
            s15 = (s + (64'd1 << 46)) >> 47;
            case (q % 4)
                0:       begin cv = int'(c15);  sv = int'(s15);  end
                1:       begin cv = -int'(s15); sv = int'(c15);  end
                2:       begin cv = -int'(c15); sv = -int'(s15); end
                default: begin cv = int'(s15);  sv = -int'(c15); end
            endcase
            cos_tw[m] = (cv > 32767) ? 32767 : cv;
            sin_tw[m] = (sv > 32767) ? 32767 : sv;
        end
    end

    // Offers one sample, waits for the request to be taken, then updates the prediction.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re,
                               input logic signed [SAMPLE_BITS-1:0] im);
        longint   acc_re;
        longint   acc_im;
        int       m;
        dft_bin_t nb;
        if (idle_in && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_re <= re;
        sample_im <= im;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        frame_re[frame_fill] = re;
        frame_im[frame_fill] = im;
        frame_fill++;
        if (frame_fill == NPTS)
        begin
            frame_fill = 0;
            for (int b = 0; b < NPTS; b++)
            begin
                acc_re = 0;
                acc_im = 0;
                for (int k = 0; k < NPTS; k++)
                begin
                    m = (b * k) % NPTS;
                    acc_re += longint'(frame_re[k]) * cos_tw[m]
                              + longint'(frame_im[k]) * sin_tw[m];
                    acc_im += longint'(frame_im[k]) * cos_tw[m]
                              - longint'(frame_re[k]) * sin_tw[m];
                end
                nb.index = b[BIN_BITS-1:0];
                nb.re    = acc_re[ACC_BITS-1:0];
                nb.im    = acc_im[ACC_BITS-1:0];
                nb.last  = (b == NPTS - 1);
                bins_due = {bins_due, nb};
            end
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_part();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: return S_MIN;
            1: return S_MAX;
            2: w = $urandom_range(0, 31) - 16;
            default: w = $urandom();
        endcase
        return w[SAMPLE_BITS-1:0];
    endfunction

    // One full-scale positive sample, then the most negative value everywhere else.
    task automatic test_constant_min();
        send_sample(S_MAX, S_MAX);
        for (int k = 1; k < NPTS; k++)
        begin
            send_sample(S_MIN, S_MIN);
        end
    endtask

    // Extreme samples whose signs follow bin 5's twiddles, driving that bin near full scale.
    task automatic test_aligned_tone();
        int m;
        for (int k = 0; k < NPTS; k++)
        begin
            m = (5 * k) % NPTS;
            send_sample(cos_tw[m] >= 0 ? S_MAX : S_MIN, sin_tw[m] >= 0 ? S_MAX : S_MIN);
        end
    endtask

    task automatic test_random_frames(input int frames);
        idle_in = 1'b1;
        stall_out <= 1'b1;
        for (int k = 0; k < frames * NPTS; k++)
        begin
            send_sample(random_part(), random_part());
        end
    endtask

    // The receiver stops for a long stretch once a frame is complete, while the next
    // frame is already being offered, so the block has to hold off its input.
    task automatic test_stalled_output();
        idle_in = 1'b0;
        for (int k = 0; k < NPTS; k++)
        begin
            send_sample(random_part(), random_part());
        end
        hold_reqs <= hold_reqs + 1;
        for (int k = 0; k < NPTS; k++)
        begin
            send_sample(random_part(), random_part());
        end
    endtask

    task automatic test_quiet_finish();
        idle_in = 1'b0;
        stall_out <= 1'b0;
        for (int k = 0; k < NPTS; k++)
        begin
            send_sample(random_part(), random_part());
        end
    endtask

    // Receiver: random stall bursts, plus the long hold-off when one is requested.
    initial
    begin
        out_ready <= 1'b0;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_reqs != holds_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else if (stall_out && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (bins_due.size() == 0)
            begin
                $error("bin %0d arrived with no result pending", bin_index);
                errors++;
            end
            else
            begin
                due_bin = bins_due.pop_front();
                if (bin_index !== due_bin.index)
                begin
                    $error("bin_index mismatch: expected %0d, got %0d", due_bin.index, bin_index);
                    errors++;
                end
                if (bin_re !== due_bin.re)
                begin
                    $error("bin_re mismatch: expected %0d, got %0d",
                           $signed(due_bin.re), $signed(bin_re));
                    errors++;
                end
                if (bin_im !== due_bin.im)
                begin
                    $error("bin_im mismatch: expected %0d, got %0d",
                           $signed(due_bin.im), $signed(bin_im));
                    errors++;
                end
                if (last_bin !== due_bin.last)
                begin
                    $error("last_bin mismatch: expected %0d, got %0d", due_bin.last, last_bin);
                    errors++;
                end
            end
        end
    end

    // Ends the run if neither channel moves a request for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        sample_re <= '0;
        sample_im <= '0;
        stall_out <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_constant_min();
        test_aligned_tone();
        test_random_frames(2);
        test_stalled_output();
        test_quiet_finish();
        in_valid <= 1'b0;

        while (bins_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (NPTS + 8) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
